FILE: sv/pnci_pkg.sv
// Shared types, constants and colour functions for the palette nearest-colour block.
// Depends on nothing; the seed, cell, top level and testbench import it.
package pnci_pkg;

   localparam int SYS_LOW_COUNT = 10;
   localparam int SYS_HIGH_BASE = 246;
   localparam int SYS_COUNT     = 20;
   localparam int CELL_COUNT    = 2 * SYS_LOW_COUNT;
   localparam int DIST_W        = 10;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

   // data handed from one cell to the next
   typedef struct packed {
      color_type         pixel;
      logic [7:0]        best_idx;
      logic [DIST_W-1:0] best_dist;
   } stage_type;

   // system colours: entries 0..9, then entries 246..255
   function automatic color_type sys_color(input logic [4:0] k);
      color_type c;
      case (k)
         5'd0:    c = '{8'd0,   8'd0,   8'd0};
         5'd1:    c = '{8'd0,   8'd0,   8'd128};
         5'd2:    c = '{8'd0,   8'd128, 8'd0};
         5'd3:    c = '{8'd0,   8'd128, 8'd128};
         5'd4:    c = '{8'd128, 8'd0,   8'd0};
         5'd5:    c = '{8'd128, 8'd0,   8'd128};
         5'd6:    c = '{8'd128, 8'd128, 8'd0};
         5'd7:    c = '{8'd192, 8'd192, 8'd192};
         5'd8:    c = '{8'd192, 8'd220, 8'd192};
         5'd9:    c = '{8'd240, 8'd202, 8'd166};
         5'd10:   c = '{8'd240, 8'd251, 8'd255};
         5'd11:   c = '{8'd164, 8'd160, 8'd160};
         5'd12:   c = '{8'd128, 8'd128, 8'd128};
         5'd13:   c = '{8'd0,   8'd0,   8'd255};
         5'd14:   c = '{8'd0,   8'd255, 8'd0};
         5'd15:   c = '{8'd0,   8'd255, 8'd255};
         5'd16:   c = '{8'd255, 8'd0,   8'd0};
         5'd17:   c = '{8'd255, 8'd0,   8'd255};
         5'd18:   c = '{8'd255, 8'd255, 8'd0};
         5'd19:   c = '{8'd255, 8'd255, 8'd255};
         default: c = '{8'd0,   8'd0,   8'd0};
      endcase
      return c;
   endfunction

   // colour held at any palette entry
   function automatic color_type palette_color(input logic [7:0] idx);
      color_type  c;
      logic [7:0] k;
      k = 8'(idx - 8'(SYS_HIGH_BASE - SYS_LOW_COUNT));
      if (idx < 8'(SYS_LOW_COUNT)) begin
         c = sys_color(idx[4:0]);
      end else if (idx >= 8'(SYS_HIGH_BASE)) begin
         c = sys_color(k[4:0]);
      end else begin
         c.red   = {idx[7:6], 6'd0};
         c.green = {idx[5:3], 5'd0};
         c.blue  = {idx[2:0], 5'd0};
      end
      return c;
   endfunction

   function automatic logic [7:0] abs_diff(input logic [7:0] x, input logic [7:0] y);
      return (x >= y) ? 8'(x - y) : 8'(y - x);
   endfunction

   // Manhattan distance, at most 765
   function automatic logic [DIST_W-1:0] color_dist(input color_type a, input color_type b);
      return DIST_W'(abs_diff(a.red, b.red)) + DIST_W'(abs_diff(a.green, b.green))
           + DIST_W'(abs_diff(a.blue, b.blue));
   endfunction

endpackage

FILE: sv/pnci_seed.sv
// Head of the chain: forms the cube candidate for a pixel and its distance.
// Depends on pnci_pkg.
module pnci_seed
   import pnci_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      up_valid,
   output logic      up_ready,
   input  color_type up_pixel,
   output logic      down_valid,
   input  logic      down_ready,
   output stage_type down_stage
);

   logic      valid_ff, valid_in;
   stage_type stage_ff, stage_in;
   logic [7:0] cand;

   // stage holds an item until the next cell takes it
   assign up_ready = !valid_ff || down_ready;

   // candidate from the pixel's top bits
   always_comb begin
      cand               = {up_pixel.red[7:6], up_pixel.green[7:5], up_pixel.blue[7:5]};
      stage_in.pixel     = up_pixel;
      stage_in.best_idx  = cand;
      stage_in.best_dist = color_dist(palette_color(cand), up_pixel);
      valid_in           = up_ready ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         stage_ff <= stage_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_stage = stage_ff;

endmodule

FILE: sv/pnci_cell.sv
// One cell of the chain: tests the item against one system colour.
// Depends on pnci_pkg.
module pnci_cell
   import pnci_pkg::*;
#(
   parameter int CELL_POS = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      up_valid,
   output logic      up_ready,
   input  stage_type up_stage,
   output logic      down_valid,
   input  logic      down_ready,
   output stage_type down_stage
);

   // even cells take the low system entries, odd cells the high ones
   localparam logic [4:0] SYS_K = (CELL_POS % 2 == 0) ? 5'(CELL_POS / 2)
                                : 5'(SYS_LOW_COUNT + CELL_POS / 2);
   localparam logic [7:0] PAL_IDX = (CELL_POS % 2 == 0) ? 8'(CELL_POS / 2)
                                  : 8'(SYS_HIGH_BASE + CELL_POS / 2);
   localparam color_type SYS_RGB = sys_color(SYS_K);

   logic              valid_ff, valid_in;
   stage_type         stage_ff, stage_in;
   logic [DIST_W-1:0] sys_dist;

   assign up_ready = !valid_ff || down_ready;

   // later entry wins on a tie
   always_comb begin
      sys_dist = color_dist(SYS_RGB, up_stage.pixel);
      stage_in = up_stage;
      if (up_stage.best_dist >= sys_dist) begin
         stage_in.best_dist = sys_dist;
         stage_in.best_idx  = PAL_IDX;
      end
      valid_in = up_ready ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         stage_ff <= stage_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_stage = stage_ff;

endmodule

FILE: sv/palette_nearest_color_index.sv
// Maps each 24-bit pixel to the index of the nearest entry of a fixed 256-colour
// palette by Manhattan distance. One pixel is taken per clock unless the row is full
// and the output stalled; the result passes through the seed stage and then the row
// of 20 cells, one per system colour, each a register stage. Every stage has its own
// valid bit and holds only when its successor is full and stalled, so bubbles close
// up and input is refused only once the whole row is full.
// Depends on pnci_pkg, pnci_seed and pnci_cell.
module palette_nearest_color_index
   import pnci_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_palette_index
);

   logic      link_valid [CELL_COUNT+1];
   logic      link_ready [CELL_COUNT+1];
   stage_type link_stage [CELL_COUNT+1];
   color_type req_pixel;

   assign req_pixel = '{req_red, req_green, req_blue};

   // cube candidate
   pnci_seed u_seed (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_valid),
      .up_ready   (req_ready),
      .up_pixel   (req_pixel),
      .down_valid (link_valid[0]),
      .down_ready (link_ready[0]),
      .down_stage (link_stage[0])
   );

   // system colours in the order 0,246,1,247,...,9,255
   for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
      pnci_cell #(.CELL_POS(g)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (link_valid[g]),
         .up_ready   (link_ready[g]),
         .up_stage   (link_stage[g]),
         .down_valid (link_valid[g+1]),
         .down_ready (link_ready[g+1]),
         .down_stage (link_stage[g+1])
      );
   end

   // last cell is the output register
   assign link_ready[CELL_COUNT] = rsp_ready;
   assign rsp_valid              = link_valid[CELL_COUNT];
   assign rsp_palette_index      = link_stage[CELL_COUNT].best_idx;

endmodule

FILE: sv/pnci_checker.sv
// Port-level checks for palette_nearest_color_index, bound to the top level.
// Depends on the top level's ports only.
module pnci_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_red,
   input logic [7:0] req_green,
   input logic [7:0] req_blue,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_palette_index
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_palette_index))
      else $error("result item changed while stalled");

   // reset empties the row
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // input is refused only when the output is stalled
   a_no_early_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input refused without output back-pressure");

   // an empty output means room at the input
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input refused with an empty output");

endmodule

bind palette_nearest_color_index pnci_checker u_pnci_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_red           (req_red),
   .req_green         (req_green),
   .req_blue          (req_blue),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_palette_index (rsp_palette_index)
);

FILE: tb/testbench.sv
// Self-checking testbench for palette_nearest_color_index: directed and random pixels,
// with an independent nearest-palette-entry predictor and an in-order result check.
// Depends on pnci_pkg and the palette_nearest_color_index RTL.
module testbench
   import pnci_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUSY_PCT      = 70;
   localparam int LIGHT_PCT     = 9;
   localparam int ITEMS_PHASE   = 150;
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT   = 1000;

   typedef enum logic [1:0] {
      PHASE_STEADY,
      PHASE_SEND_IDLE,
      PHASE_RECV_STALL,
      PHASE_BOTH
   } idle_phase_e;

   typedef struct {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      idle_phase_e phase;
      bit          drain;
   } pixel_item_t;

   // system colours as {red, green, blue}: entries 0..9, then 246..255
   localparam logic [23:0] SYSTEM_RGB [0:19] = '{
      24'h000000, 24'h000080, 24'h008000, 24'h008080, 24'h800000,
      24'h800080, 24'h808000, 24'hC0C0C0, 24'hC0DCC0, 24'hF0CAA6,
      24'hF0FBFF, 24'hA4A0A0, 24'h808080, 24'h0000FF, 24'h00FF00,
      24'h00FFFF, 24'hFF0000, 24'hFF00FF, 24'hFFFF00, 24'hFFFFFF
   };

   logic       clock             = 1'b0;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_ready;
   logic [7:0] req_red           = 8'd0;
   logic [7:0] req_green         = 8'd0;
   logic [7:0] req_blue          = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready         = 1'b0;
   logic [7:0] rsp_palette_index;

   pixel_item_t pending_q [$];
   logic [7:0]  index_exp_q [$];
   int          outstanding = 0;
   int          n_fail      = 0;
   int          quiet_cycles = 0;
   idle_phase_e cur_phase   = PHASE_STEADY;

   palette_nearest_color_index i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_palette_index (rsp_palette_index)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // colour held at a palette entry
   function automatic logic [23:0] entry_rgb(input logic [7:0] idx);
      if (idx < SYS_LOW_COUNT) begin
         return SYSTEM_RGB[idx];
      end
      if (idx >= SYS_HIGH_BASE) begin
         return SYSTEM_RGB[idx - SYS_HIGH_BASE + SYS_LOW_COUNT];
      end
      return {idx[7:6], 6'd0, idx[5:3], 5'd0, idx[2:0], 5'd0};
   endfunction

   function automatic logic [DIST_W-1:0] manhattan(input logic [23:0] a, input logic [23:0] b);
      logic [DIST_W-1:0] d;
      logic [7:0]        x;
      logic [7:0]        y;
      d = '0;
      for (int ch = 0; ch < 3; ch++) begin
         x = a[8*ch +: 8];
         y = b[8*ch +: 8];
         d = d + ((x >= y) ? DIST_W'(x - y) : DIST_W'(y - x));
      end
      return d;
   endfunction

   // cube guess first, then system colours interleaved low/high; ties go to the later entry
   function automatic logic [7:0] nearest_entry(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b);
      logic [23:0]       px;
      logic [7:0]        best;
      logic [7:0]        e;
      logic [DIST_W-1:0] best_d;
      logic [DIST_W-1:0] d;
      px     = {r, g, b};
      best   = {r[7:6], g[7:5], b[7:5]};
      best_d = manhattan(entry_rgb(best), px);
      for (int i = 0; i < SYS_LOW_COUNT; i++) begin
         e = 8'(i);
         d = manhattan(entry_rgb(e), px);
         if (best_d >= d) begin
            best_d = d;
            best   = e;
         end
         e = 8'(SYS_HIGH_BASE + i);
         d = manhattan(entry_rgb(e), px);
         if (best_d >= d) begin
            best_d = d;
            best   = e;
         end
      end
      return best;
   endfunction

   function automatic int send_idle_pct(input idle_phase_e ph);
      case (ph)
         PHASE_SEND_IDLE: return BUSY_PCT;
         PHASE_BOTH:      return LIGHT_PCT;
         default:         return 0;
      endcase
   endfunction

   function automatic int recv_stall_pct(input idle_phase_e ph);
      case (ph)
         PHASE_RECV_STALL: return BUSY_PCT;
         PHASE_BOTH:       return LIGHT_PCT;
         default:          return 0;
      endcase
   endfunction

   function automatic logic [7:0] clamp_byte(input int v);
      if (v < 0) begin
         return 8'd0;
      end
      if (v > 255) begin
         return 8'd255;
      end
      return 8'(v);
   endfunction

   // one channel value: uniform, near a system colour, or on a cube boundary
   function automatic logic [7:0] pick_channel(input int mode, input logic [7:0] anchor);
      int step;
      case (mode)
         0:       return 8'($urandom_range(255));
         1:       return clamp_byte(int'(anchor) + $urandom_range(8) - 4);
         default: begin
            step = 32 * $urandom_range(8);
            return clamp_byte(step - $urandom_range(1));
         end
      endcase
   endfunction

   task automatic add_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input idle_phase_e ph, input bit drain);
      pixel_item_t it;
      it.red   = r;
      it.green = g;
      it.blue  = b;
      it.phase = ph;
      it.drain = drain;
      pending_q.push_back(it);
   endtask

   task automatic add_random(input idle_phase_e ph, input int count);
      int          mode;
      logic [23:0] anchor;
      for (int n = 0; n < count; n++) begin
         mode   = ($urandom_range(9) < 5) ? 0 : (($urandom_range(4) < 3) ? 1 : 2);
         anchor = SYSTEM_RGB[$urandom_range(19)];
         add_pixel(pick_channel(mode, anchor[23:16]), pick_channel(mode, anchor[15:8]),
                   pick_channel(mode, anchor[7:0]), ph, n == 0);
      end
   endtask

   // driver: next pixel once the previous one is taken; drain items wait for an empty pipe
   always @(posedge clock) begin
      pixel_item_t nxt;
      bit          go;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         go = 1'b0;
         if (pending_q.size() != 0) begin
            nxt = pending_q[0];
            go  = ($urandom_range(99) >= send_idle_pct(nxt.phase));
            if (nxt.drain && (outstanding != 0 || req_valid)) begin
               go = 1'b0;
            end
         end
         if (go) begin
            void'(pending_q.pop_front());
            req_valid <= 1'b1;
            req_red   <= nxt.red;
            req_green <= nxt.green;
            req_blue  <= nxt.blue;
            cur_phase <= nxt.phase;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: predict on each accepted pixel, check each accepted result in order
   always @(posedge clock) begin
      logic [7:0] want;
      if (reset) begin
         rsp_ready   <= 1'b0;
         outstanding <= 0;
      end else begin
         if (req_valid && req_ready) begin
            index_exp_q.push_back(nearest_entry(req_red, req_green, req_blue));
         end
         if (rsp_valid && rsp_ready) begin
            if (index_exp_q.size() == 0) begin
               $error("palette_index: unexpected result %0d, nothing pending", rsp_palette_index);
               n_fail++;
            end else begin
               want = index_exp_q.pop_front();
               if (want !== rsp_palette_index) begin
                  $error("palette_index: expected %0d, actual %0d", want, rsp_palette_index);
                  n_fail++;
               end
            end
         end
         outstanding <= index_exp_q.size();
         rsp_ready   <= ($urandom_range(99) >= recv_stall_pct(cur_phase));
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      // directed: black, white, every system colour (some exact hits tie with the cube),
      // guesses landing in system slots, cube boundaries
      for (int k = 0; k < SYS_COUNT; k++) begin
         add_pixel(SYSTEM_RGB[k][23:16], SYSTEM_RGB[k][15:8], SYSTEM_RGB[k][7:0],
                   PHASE_STEADY, 1'b0);
      end
      add_pixel(8'd0,   8'd32,  8'd32,  PHASE_STEADY, 1'b0);
      add_pixel(8'd255, 8'd200, 8'd200, PHASE_STEADY, 1'b0);
      add_pixel(8'd63,  8'd31,  8'd31,  PHASE_STEADY, 1'b0);
      add_pixel(8'd127, 8'd127, 8'd127, PHASE_STEADY, 1'b0);
      add_pixel(8'd64,  8'd96,  8'd160, PHASE_STEADY, 1'b0);

      add_random(PHASE_STEADY,     ITEMS_PHASE);
      add_random(PHASE_SEND_IDLE,  ITEMS_PHASE);
      add_random(PHASE_RECV_STALL, ITEMS_PHASE);
      add_random(PHASE_BOTH,       ITEMS_PHASE);
      add_random(PHASE_STEADY,     30);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_valid) @(negedge clock);
      while (index_exp_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (index_exp_q.size() != 0) begin
         $error("palette_index: %0d results never arrived", index_exp_q.size());
         n_fail++;
      end
      if (n_fail == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/pnci_pkg.sv
sv/pnci_seed.sv
sv/pnci_cell.sv
sv/palette_nearest_color_index.sv
sv/pnci_checker.sv
tb/testbench.sv
